// ===== rtl/core/mttl_pkg.sv =====
// Package of shared types, constants and datapath command codes for the rate limiter.
`timescale 1ns / 1ps
package mttl_pkg;

    localparam int DefNumClients    = 4;
    localparam int DefNumPriorities = 4;
    localparam int DefQueueDepth    = 4;
    localparam int MaxResults       = 64;
    localparam int ResCntW          = $clog2(MaxResults + 1);

    localparam int BytesW  = 32;
    localparam int TagW    = 8;
    localparam int PeriodW = 24;
    localparam int CfgIdxW = 3;
    localparam int CfgW    = 32;
    localparam int NumBurstRegs = 4;

    localparam logic [CfgIdxW-1:0] REG_PERIOD = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_BURST0 = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_BURST1 = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_BURST2 = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_BURST3 = 3'd4;

    localparam logic [PeriodW-1:0] PERIOD_RESET = 24'd100000;
    localparam logic [BytesW-1:0]  BURST_RESET  = 32'd65536;

    localparam logic [1:0] EV_GRANT   = 2'd0;
    localparam logic [1:0] EV_QUEUED  = 2'd1;
    localparam logic [1:0] EV_REFILL  = 2'd2;
    localparam logic [1:0] EV_DROPPED = 2'd3;

    localparam logic ACT_REQUEST = 1'b0;
    localparam logic ACT_TICK    = 1'b1;

    localparam int OpW = 4;
    localparam logic [OpW-1:0] OP_NONE      = 4'd0;
    localparam logic [OpW-1:0] OP_LOAD      = 4'd1;
    localparam logic [OpW-1:0] OP_CLAMP     = 4'd2;
    localparam logic [OpW-1:0] OP_TAKE      = 4'd3;
    localparam logic [OpW-1:0] OP_DECIDE    = 4'd4;
    localparam logic [OpW-1:0] OP_TICK_DEC  = 4'd5;
    localparam logic [OpW-1:0] OP_NEXT_CLI  = 4'd6;
    localparam logic [OpW-1:0] OP_REF_START = 4'd7;
    localparam logic [OpW-1:0] OP_REF_READ  = 4'd8;
    localparam logic [OpW-1:0] OP_GRANT     = 4'd9;
    localparam logic [OpW-1:0] OP_NEXT_PRIO = 4'd10;
    localparam logic [OpW-1:0] OP_FLUSH     = 4'd11;

    typedef struct packed {
        logic [OpW-1:0] op;
    } mttl_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic client_ok;
        logic emit_ok;
        logic flush_ok;
        logic go_refill;
        logic refill_due;
        logic client_last;
        logic head_go;
        logic tok_lt_head;
        logic prio_zero;
    } mttl_status_t;

    typedef struct packed {
        logic [1:0]        event_kind;
        logic [TagW-1:0]   tag;
        logic [1:0]        client_out;
        logic [1:0]        priority_out;
        logic [BytesW-1:0] bytes_out;
        logic              last;
    } mttl_result_t;

endpackage

// ===== rtl/core/mttl_if.sv =====
// Request and result channel interfaces of the rate limiter.
`timescale 1ns / 1ps
interface mttl_req_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [1:0]  client;
    logic [1:0]  priority_req;
    logic [31:0] byte_len;
    logic [7:0]  request_tag;
    modport source (output valid, action, client, priority_req, byte_len, request_tag,
                    input ready);
    modport sink (input valid, action, client, priority_req, byte_len, request_tag,
                  output ready);
endinterface

interface mttl_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    logic [7:0]  tag;
    logic [1:0]  client_out;
    logic [1:0]  priority_out;
    logic [31:0] bytes_out;
    logic        last;
    modport source (output valid, event_kind, tag, client_out, priority_out, bytes_out, last,
                    input ready);
    modport sink (input valid, event_kind, tag, client_out, priority_out, bytes_out, last,
                  output ready);
endinterface

// ===== rtl/core/mttl_ctrl.sv =====
// Controller state machine of the rate limiter.
`timescale 1ns / 1ps
module mttl_ctrl
    import mttl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_action,
    output logic         in_ready,
    input  mttl_status_t st,
    output mttl_cmd_t    cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLAMP  = 4'd1;
    localparam logic [3:0] S_TAKE   = 4'd2;
    localparam logic [3:0] S_DECIDE = 4'd3;
    localparam logic [3:0] S_TDEC   = 4'd4;
    localparam logic [3:0] S_TTEST  = 4'd5;
    localparam logic [3:0] S_RSTART = 4'd6;
    localparam logic [3:0] S_RHEAD  = 4'd7;
    localparam logic [3:0] S_RCHECK = 4'd8;
    localparam logic [3:0] S_FLUSH  = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = (in_action == ACT_TICK) ? S_TDEC : S_CLAMP;
                end
            end
            S_CLAMP:
            begin
                if (!st.client_ok)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.op     = OP_CLAMP;
                    state_next = S_TAKE;
                end
            end
            S_TAKE:
            begin
                cmd.op     = OP_TAKE;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (st.emit_ok)
                begin
                    cmd.op     = OP_DECIDE;
                    state_next = st.go_refill ? S_RSTART : S_FLUSH;
                end
            end
            S_TDEC:
            begin
                cmd.op     = OP_TICK_DEC;
                state_next = S_TTEST;
            end
            S_TTEST:
            begin
                if (st.refill_due)
                begin
                    state_next = S_RSTART;
                end
                else if (st.client_last)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    cmd.op     = OP_NEXT_CLI;
                    state_next = S_TDEC;
                end
            end
            S_RSTART:
            begin
                cmd.op     = OP_REF_START;
                state_next = S_RHEAD;
            end
            S_RHEAD, S_RCHECK:
            begin
                if (state_reg == S_RHEAD && st.head_go)
                begin
                    cmd.op     = OP_REF_READ;
                    state_next = S_RCHECK;
                end
                else if (state_reg == S_RCHECK && !st.tok_lt_head)
                begin
                    if (st.emit_ok)
                    begin
                        cmd.op     = OP_GRANT;
                        state_next = S_RHEAD;
                    end
                end
                else if (!st.prio_zero)
                begin
                    cmd.op     = OP_NEXT_PRIO;
                    state_next = S_RHEAD;
                end
                else if (st.is_tick && !st.client_last)
                begin
                    // This client's refill is over; the tick moves on to the next one.
                    cmd.op     = OP_NEXT_CLI;
                    state_next = S_TDEC;
                end
                else
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (st.flush_ok)
                begin
                    cmd.op     = OP_FLUSH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/mttl_dp.sv =====
// Datapath of the rate limiter: buckets, countdowns, queue memory and result registers.
`timescale 1ns / 1ps
module mttl_dp
    import mttl_pkg::*;
#(
    parameter int CLIENT_COUNT   = DefNumClients,
    parameter int NUM_PRIORITIES = DefNumPriorities,
    parameter int QUEUE_DEPTH    = DefQueueDepth
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [CfgW-1:0]    cfg_data,
    input  logic               in_action,
    input  logic [1:0]         in_client,
    input  logic [1:0]         in_priority,
    input  logic [BytesW-1:0]  in_bytes,
    input  logic [TagW-1:0]    in_tag,
    input  mttl_cmd_t          cmd,
    output mttl_status_t       st,
    output logic               out_valid,
    input  logic               out_ready,
    output mttl_result_t       out_data
);

    localparam int NQ  = CLIENT_COUNT * NUM_PRIORITIES;
    localparam int NE  = NQ * QUEUE_DEPTH;
    localparam int CIW = (CLIENT_COUNT > 1) ? $clog2(CLIENT_COUNT) : 1;
    localparam int PIW = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
    localparam int QIW = (NQ > 1) ? $clog2(NQ) : 1;
    localparam int HW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int SW  = CW + 1;
    localparam int AW  = (NE > 1) ? $clog2(NE) : 1;
    localparam int EW  = BytesW + TagW;

    logic [PeriodW-1:0] period_reg;
    logic [BytesW-1:0]  burst_reg [NumBurstRegs];
    logic [BytesW-1:0]  tok_reg   [CLIENT_COUNT];
    logic [PeriodW-1:0] cd_reg    [CLIENT_COUNT];
    logic [HW-1:0]      head_reg  [NQ];
    logic [CW-1:0]      cnt_reg   [NQ];
    logic [EW-1:0]      mem       [NE];
    logic [EW-1:0]      rd_reg;

    logic               tick_reg;
    logic               ok_reg;
    logic [CIW-1:0]     c_reg;
    logic [PIW-1:0]     p_reg;
    logic [BytesW-1:0]  bytes_reg;
    logic [BytesW-1:0]  take_reg;
    logic [TagW-1:0]    tag_reg;
    logic [ResCntW-1:0] n_reg;

    logic               hold_valid_reg;
    mttl_result_t       hold_reg;
    mttl_result_t       hold_last;
    logic               out_valid_reg;
    mttl_result_t       out_reg;

    logic [QIW-1:0]     q_idx;
    logic [HW-1:0]      head_cur;
    logic [CW-1:0]      cnt_cur;
    logic [SW-1:0]      slot_sum;
    logic [HW-1:0]      slot;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    logic [1:0]         cidx;
    logic [BytesW-1:0]  burst_cur;
    logic [BytesW-1:0]  tok_cur;
    logic [BytesW:0]    tok_sum;
    logic               rem_zero;
    logic               q_full;
    logic               has_work;
    logic               emit;
    logic               out_free;
    mttl_result_t       new_res;

    assign q_idx     = QIW'(int'(c_reg) * NUM_PRIORITIES + int'(p_reg));
    assign head_cur  = head_reg[q_idx];
    assign cnt_cur   = cnt_reg[q_idx];
    assign cidx      = 2'(c_reg);
    assign burst_cur = burst_reg[cidx];
    assign tok_cur   = tok_reg[c_reg];
    assign tok_sum   = {1'b0, tok_cur} + {1'b0, burst_cur};
    assign rem_zero  = (bytes_reg == take_reg);
    assign q_full    = (cnt_cur == CW'(QUEUE_DEPTH));

    always_comb
    begin
        slot_sum = SW'(head_cur) + SW'(cnt_cur);
        if (slot_sum >= SW'(QUEUE_DEPTH))
        begin
            slot_sum = slot_sum - SW'(QUEUE_DEPTH);
        end
        slot = HW'(slot_sum);
    end

    assign wr_addr = AW'(int'(q_idx) * QUEUE_DEPTH + int'(slot));
    assign rd_addr = AW'(int'(q_idx) * QUEUE_DEPTH + int'(head_cur));

    always_comb
    begin
        has_work = 1'b0;
        for (int pi = 0; pi < NUM_PRIORITIES; pi++)
        begin
            if (cnt_reg[QIW'(int'(c_reg) * NUM_PRIORITIES + pi)] != '0)
            begin
                has_work = 1'b1;
            end
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        st.is_tick     = tick_reg;
        st.client_ok   = ok_reg;
        st.emit_ok     = !hold_valid_reg || out_free;
        st.flush_ok    = !hold_valid_reg || out_free;
        st.go_refill   = !rem_zero && !q_full && (cd_reg[c_reg] == '0);
        st.refill_due  = (cd_reg[c_reg] == '0) && has_work;
        st.client_last = (c_reg == CIW'(CLIENT_COUNT - 1));
        st.head_go     = (cnt_cur != '0) && (n_reg < ResCntW'(MaxResults));
        st.tok_lt_head = (tok_cur < rd_reg[BytesW-1:0]);
        st.prio_zero   = (p_reg == '0);
    end

    always_comb
    begin
        hold_last      = hold_reg;
        hold_last.last = 1'b1;
    end

    // Result produced by this command, if any.
    always_comb
    begin
        emit                 = 1'b0;
        new_res.tag          = tag_reg;
        new_res.client_out   = 2'(c_reg);
        new_res.priority_out = 2'(p_reg);
        new_res.last         = 1'b0;
        new_res.event_kind   = EV_GRANT;
        new_res.bytes_out    = take_reg;
        if (cmd.op == OP_DECIDE)
        begin
            emit = 1'b1;
            if (rem_zero)
            begin
                new_res.event_kind = EV_GRANT;
            end
            else if (q_full)
            begin
                new_res.event_kind = EV_DROPPED;
                new_res.bytes_out  = '0;
            end
            else
            begin
                new_res.event_kind = EV_QUEUED;
            end
        end
        else if (cmd.op == OP_GRANT)
        begin
            emit               = 1'b1;
            new_res.event_kind = EV_REFILL;
            new_res.tag        = rd_reg[EW-1:BytesW];
            new_res.bytes_out  = rd_reg[BytesW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg     <= PERIOD_RESET;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < NumBurstRegs; i++)
            begin
                burst_reg[i] <= BURST_RESET;
            end
            for (int i = 0; i < CLIENT_COUNT; i++)
            begin
                tok_reg[i] <= '0;
                cd_reg[i]  <= '0;
            end
            for (int i = 0; i < NQ; i++)
            begin
                head_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PERIOD: period_reg   <= cfg_data[PeriodW-1:0];
                    REG_BURST0: burst_reg[0] <= cfg_data;
                    REG_BURST1: burst_reg[1] <= cfg_data;
                    REG_BURST2: burst_reg[2] <= cfg_data;
                    REG_BURST3: burst_reg[3] <= cfg_data;
                    default: ;
                endcase
            end

            if ((emit || cmd.op == OP_FLUSH) && hold_valid_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (emit)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (cmd.op == OP_FLUSH)
            begin
                hold_valid_reg <= 1'b0;
            end

            case (cmd.op)
                OP_DECIDE:
                begin
                    if (rem_zero)
                    begin
                        tok_reg[c_reg] <= tok_cur - take_reg;
                    end
                    else if (!q_full)
                    begin
                        tok_reg[c_reg] <= tok_cur - take_reg;
                        cnt_reg[q_idx] <= cnt_cur + 1'b1;
                    end
                end
                OP_TICK_DEC:
                begin
                    if (cd_reg[c_reg] != '0)
                    begin
                        cd_reg[c_reg] <= cd_reg[c_reg] - 1'b1;
                    end
                end
                OP_REF_START:
                begin
                    cd_reg[c_reg] <= period_reg;
                    // A burst lowered below the present fill cuts the bucket down too.
                    if (tok_sum > {1'b0, burst_cur})
                    begin
                        tok_reg[c_reg] <= burst_cur;
                    end
                    else
                    begin
                        tok_reg[c_reg] <= tok_sum[BytesW-1:0];
                    end
                end
                OP_GRANT:
                begin
                    tok_reg[c_reg] <= tok_cur - rd_reg[BytesW-1:0];
                    cnt_reg[q_idx] <= cnt_cur - 1'b1;
                    if (head_cur == HW'(QUEUE_DEPTH - 1))
                    begin
                        head_reg[q_idx] <= '0;
                    end
                    else
                    begin
                        head_reg[q_idx] <= head_cur + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit && hold_valid_reg)
        begin
            out_reg <= hold_reg;
        end
        else if (cmd.op == OP_FLUSH && hold_valid_reg)
        begin
            out_reg <= hold_last;
        end
        if (emit)
        begin
            hold_reg <= new_res;
            n_reg    <= n_reg + 1'b1;
        end

        case (cmd.op)
            OP_LOAD:
            begin
                tick_reg  <= in_action;
                ok_reg    <= (int'(in_client) < CLIENT_COUNT);
                c_reg     <= (in_action == ACT_TICK) ? '0 : CIW'(in_client);
                if (int'(in_priority) >= NUM_PRIORITIES)
                begin
                    p_reg <= PIW'(NUM_PRIORITIES - 1);
                end
                else
                begin
                    p_reg <= PIW'(in_priority);
                end
                bytes_reg <= in_bytes;
                tag_reg   <= in_tag;
                n_reg     <= '0;
            end
            OP_CLAMP:
            begin
                if (bytes_reg > burst_cur)
                begin
                    bytes_reg <= burst_cur;
                end
            end
            OP_TAKE:
            begin
                take_reg <= (tok_cur < bytes_reg) ? tok_cur : bytes_reg;
            end
            OP_DECIDE:
            begin
                if (!rem_zero && !q_full)
                begin
                    mem[wr_addr] <= {tag_reg, bytes_reg - take_reg};
                end
            end
            OP_NEXT_CLI:
            begin
                c_reg <= c_reg + 1'b1;
            end
            OP_REF_START:
            begin
                p_reg <= PIW'(NUM_PRIORITIES - 1);
            end
            OP_REF_READ:
            begin
                rd_reg <= mem[rd_addr];
            end
            OP_NEXT_PRIO:
            begin
                p_reg <= p_reg - 1'b1;
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== rtl/core/multi_tenant_token_bucket_limiter.sv =====
// Top level of the multi-tenant token bucket rate limiter.
// One request is worked at a time. A byte request takes what tokens it can and is
// granted, queued or dropped; one whose client is out of range ends without a result.
// A refill follows when the client's countdown has run out and a remainder was queued;
// a tick steps each client's countdown down and refills a client whose countdown has
// run out and that has queued work. A refill reloads the countdown and tops up the
// bucket, then checks each priority, granting each queued entry that fits and moving on
// at a head that does not; every queue head is read from the queue memory through its
// single registered read port. Results leave through an output register, and the last
// one of a request carries last; with a stalled result channel the block waits. The
// queue memory holds nothing meaningful until written and needs no clearing pass.
`timescale 1ns / 1ps
module multi_tenant_token_bucket_limiter
    import mttl_pkg::*;
#(
    parameter int CLIENT_COUNT   = DefNumClients,
    parameter int NUM_PRIORITIES = DefNumPriorities,
    parameter int QUEUE_DEPTH    = DefQueueDepth
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [CfgW-1:0]    cfg_data,
    mttl_req_if.sink           req,
    mttl_res_if.source         res
);

    mttl_cmd_t    cmd;
    mttl_status_t st;
    mttl_result_t out_data;

    mttl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_action (req.action),
        .in_ready  (req.ready),
        .st        (st),
        .cmd       (cmd)
    );

    mttl_dp #(
        .CLIENT_COUNT   (CLIENT_COUNT),
        .NUM_PRIORITIES (NUM_PRIORITIES),
        .QUEUE_DEPTH    (QUEUE_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_action   (req.action),
        .in_client   (req.client),
        .in_priority (req.priority_req),
        .in_bytes    (req.byte_len),
        .in_tag      (req.request_tag),
        .cmd         (cmd),
        .st          (st),
        .out_valid   (res.valid),
        .out_ready   (res.ready),
        .out_data    (out_data)
    );

    assign res.event_kind   = out_data.event_kind;
    assign res.tag          = out_data.tag;
    assign res.client_out   = out_data.client_out;
    assign res.priority_out = out_data.priority_out;
    assign res.bytes_out    = out_data.bytes_out;
    assign res.last         = out_data.last;

endmodule
